### sv/plsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plsf_pkg;

  typedef enum logic [2:0] {
    MODE_LOCKED       = 3'd0,
    MODE_LOCKED_OUT   = 3'd1,
    MODE_UNLOCKED     = 3'd2,
    MODE_PROMPT_FILL  = 3'd3,
    MODE_CONFIRM_TYPE = 3'd4,
    MODE_PROMPT_SAVE  = 3'd5,
    MODE_EDIT         = 3'd6,
    MODE_SELECT       = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_TAP    = 3'd1,
    ACT_HOLD   = 3'd2,
    ACT_UNLOCK = 3'd3,
    ACT_FILL   = 3'd4,
    ACT_SAVE   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    REG_AUTOLOCK     = 2'd0,
    REG_TOUCH_FILL   = 2'd1,
    REG_LOCKOUT_AFT  = 2'd2,
    REG_WIPE_AFT     = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] AUTOLOCK_DEFAULT = 16'd300;
  localparam logic [7:0]  LOCKOUT_DEFAULT  = 8'd5;
  localparam logic [7:0]  WIPE_DEFAULT     = 8'd10;
  localparam logic [9:0]  LOCKOUT_BASE     = 10'd3;
  localparam int          LOCKOUT_STEP     = 2;
  localparam logic [9:0]  LOCKOUT_MAX      = 10'd1023;
  localparam logic [7:0]  FAIL_MAX         = 8'd255;
  localparam logic [15:0] IDLE_MAX         = 16'hFFFF;

endpackage

`default_nettype wire

### sv/pin_lockout_session_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

// Each accepted input transaction writes its result into the output register.
// Throughput: one event per cycle; the whole session update is one pass of logic
// between the state registers, so s_axis_tready only drops while a result is stalled.
// Reset (rst, synchronous): mode locked, session closed, not wiped, all counters zero,
// configuration back to autolock 300, touch-for-fill on, lockout at 5, wipe at 10.
module pin_lockout_session_fsm
  import plsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // event stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [0] pin_ok, [1] request_ok,
                                          // [2] record_requires_touch, [7:3] zero
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] action
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [0] accepted, [3:1] device_mode,
                                          // [4] session_open, [5] wiped_flag,
                                          // [15:6] lockout_left, [23:16] failure_count
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic [15:0] autolock_ticks;
  logic        touch_fill_en;
  logic [7:0]  lockout_after_failures;
  logic [7:0]  wipe_after_failures;

  // session state
  mode_t       mode,            mode_next;
  logic        open_flag,       open_flag_next;
  logic        wipe_flag,       wipe_flag_next;
  logic [7:0]  fail_counter,    fail_counter_next;
  logic [9:0]  lockout_counter, lockout_counter_next;
  logic [15:0] idle_counter,    idle_counter_next;
  logic        acc_next;

  logic        in_fire;
  action_t     action;
  logic        pin_ok, request_ok, record_touch;

  // scratch values for the update
  logic [7:0]  fail_inc;
  logic [7:0]  extra;
  logic [9:0]  lock_len;
  logic [15:0] idle_inc;
  logic [9:0]  lock_dec;
  logic        usable;
  mode_t       closed_mode;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign action       = action_t'(s_axis_tuser);
  assign pin_ok       = s_axis_tdata[0];
  assign request_ok   = s_axis_tdata[1];
  assign record_touch = s_axis_tdata[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      autolock_ticks         <= AUTOLOCK_DEFAULT;
      touch_fill_en          <= 1'b1;
      lockout_after_failures <= LOCKOUT_DEFAULT;
      wipe_after_failures    <= WIPE_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AUTOLOCK: begin
          autolock_ticks <= (cfg_data == 16'd0) ? AUTOLOCK_DEFAULT : cfg_data;
        end
        REG_TOUCH_FILL:  touch_fill_en          <= cfg_data[0];
        REG_LOCKOUT_AFT: lockout_after_failures <= cfg_data[7:0];
        REG_WIPE_AFT:    wipe_after_failures    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next            = mode;
    open_flag_next       = open_flag;
    wipe_flag_next       = wipe_flag;
    fail_counter_next    = fail_counter;
    lockout_counter_next = lockout_counter;
    idle_counter_next    = idle_counter;
    acc_next             = 1'b0;

    fail_inc    = (fail_counter < FAIL_MAX) ? fail_counter + 8'd1 : fail_counter;
    extra       = fail_inc - lockout_after_failures;
    lock_len    = LOCKOUT_BASE + 10'({2'b00, extra} * 10'(LOCKOUT_STEP));
    if (lock_len > LOCKOUT_MAX) begin
      lock_len = LOCKOUT_MAX;
    end
    idle_inc    = (idle_counter < IDLE_MAX) ? idle_counter + 16'd1 : idle_counter;
    lock_dec    = lockout_counter - 10'd1;
    usable      = open_flag && !wipe_flag && (mode != MODE_LOCKED_OUT);
    closed_mode = (mode == MODE_LOCKED_OUT) ? MODE_LOCKED_OUT : MODE_LOCKED;

    unique case (action)
      ACT_TICK: begin
        if (mode == MODE_LOCKED_OUT && lockout_counter != 10'd0) begin
          lockout_counter_next = lock_dec;
          if (lock_dec == 10'd0 && !wipe_flag) begin
            mode_next = MODE_LOCKED;
          end
        end else if (open_flag && mode != MODE_LOCKED_OUT) begin
          if (idle_inc >= autolock_ticks) begin
            open_flag_next    = 1'b0;
            idle_counter_next = 16'd0;
            mode_next         = MODE_LOCKED;
          end else begin
            idle_counter_next = idle_inc;
          end
        end
      end
      ACT_TAP: begin
        idle_counter_next = 16'd0;
        if (open_flag) begin
          priority case (mode)
            MODE_PROMPT_FILL:  mode_next = MODE_CONFIRM_TYPE;
            MODE_CONFIRM_TYPE: mode_next = MODE_UNLOCKED;
            MODE_PROMPT_SAVE:  mode_next = MODE_EDIT;
            default: ;
          endcase
        end
      end
      ACT_HOLD: begin
        idle_counter_next = 16'd0;
        if (open_flag) begin
          priority case (mode)
            MODE_UNLOCKED:    mode_next = MODE_SELECT;
            MODE_PROMPT_FILL: mode_next = MODE_CONFIRM_TYPE;
            MODE_EDIT:        mode_next = MODE_UNLOCKED;
            default: ;
          endcase
        end
      end
      ACT_UNLOCK: begin
        if (!wipe_flag && !(mode == MODE_LOCKED_OUT && lockout_counter != 10'd0)) begin
          if (pin_ok) begin
            fail_counter_next    = 8'd0;
            lockout_counter_next = 10'd0;
            open_flag_next       = 1'b1;
            mode_next            = MODE_UNLOCKED;
            idle_counter_next    = 16'd0;
            acc_next             = 1'b1;
          end else begin
            open_flag_next    = 1'b0;
            idle_counter_next = 16'd0;
            mode_next         = closed_mode;
            fail_counter_next = fail_inc;
            if (fail_inc >= wipe_after_failures) begin
              wipe_flag_next       = 1'b1;
              mode_next            = MODE_LOCKED_OUT;
              lockout_counter_next = 10'd0;
              // threshold may have been lowered below the running count
              if (wipe_after_failures != 8'd0 && fail_inc > wipe_after_failures) begin
                fail_counter_next = wipe_after_failures;
              end
            end else if (fail_inc >= lockout_after_failures) begin
              mode_next            = MODE_LOCKED_OUT;
              lockout_counter_next = lock_len;
            end
          end
        end
      end
      ACT_FILL: begin
        if (usable && request_ok) begin
          idle_counter_next = 16'd0;
          mode_next = (touch_fill_en || record_touch) ? MODE_PROMPT_FILL
                                                      : MODE_CONFIRM_TYPE;
          acc_next  = 1'b1;
        end
      end
      ACT_SAVE: begin
        if (usable && request_ok) begin
          idle_counter_next = 16'd0;
          mode_next         = MODE_PROMPT_SAVE;
          acc_next          = 1'b1;
        end
      end
      default: ;  // unknown events leave the state alone
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_LOCKED;
      open_flag       <= 1'b0;
      wipe_flag       <= 1'b0;
      fail_counter    <= 8'd0;
      lockout_counter <= 10'd0;
      idle_counter    <= 16'd0;
    end else if (in_fire) begin
      mode            <= mode_next;
      open_flag       <= open_flag_next;
      wipe_flag       <= wipe_flag_next;
      fail_counter    <= fail_counter_next;
      lockout_counter <= lockout_counter_next;
      idle_counter    <= idle_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {fail_counter_next, lockout_counter_next, wipe_flag_next,
                       open_flag_next, mode_next, acc_next};
    end
  end

  // a wipe is permanent
  a_wipe_sticky: assert property (@(posedge clk) disable iff (rst)
    wipe_flag |=> wipe_flag)
    else $error("wipe flag cleared");

  // an open session is never wiped nor locked out
  a_open_usable: assert property (@(posedge clk) disable iff (rst)
    open_flag |-> (!wipe_flag && mode != MODE_LOCKED_OUT))
    else $error("open session in lockout or wiped");

  // a running lockout countdown only exists in the locked-out mode
  a_lockout_mode: assert property (@(posedge clk) disable iff (rst)
    (lockout_counter != 10'd0) |-> (mode == MODE_LOCKED_OUT))
    else $error("lockout count outside locked-out mode");

  // state only moves when an event is taken
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> ($stable(mode) && $stable(fail_counter) && $stable(idle_counter)))
    else $error("state changed without an event");

endmodule

`default_nettype wire
